[rtl/core/cfn_pkg.sv]
// Shared types, constants and microcode program of the calendar field normalizer.
package cfn_pkg;

    localparam int FIELD_W = 16;
    localparam int WIDE_W  = 17;
    localparam int MON_W   = 4;
    localparam int ALLOW_W = 2;
    localparam int PROD_W  = 35;

    localparam logic [ALLOW_W-1:0] ALLOW_RESET = 2'd1;
    localparam logic [MON_W-1:0]   LAST_MONTH  = 4'd11;
    localparam logic [MON_W-1:0]   MONTHS      = 4'd12;
    localparam logic [14:0]        SEC_MAX     = 15'd59;

    // floor(u / 60) = (u * K60) >> 23 and floor(u / 24) = (u * K24) >> 22, exact for u < 2**17
    localparam logic [17:0] K60      = 18'd139811;
    localparam logic [17:0] K24      = 18'd174763;
    localparam logic [17:0] OFF60    = 18'd61440;  // 60 * 1024 keeps the dividend positive
    localparam logic [17:0] OFF24    = 18'd49152;  // 24 * 2048
    localparam logic [17:0] BIAS60   = 18'd1024;
    localparam logic [17:0] BIAS24   = 18'd2048;

    // 4 years are 1461 days from any start month; 64 years are 16 such blocks
    localparam logic signed [16:0] DAYS_4Y   = 17'sd1461;
    localparam logic signed [16:0] DAYS_64Y  = 17'sd23376;
    localparam logic signed [16:0] YEARS_4   = 17'sd4;
    localparam logic signed [16:0] YEARS_64  = 17'sd64;

    typedef enum logic [3:0] {
        STEP_WAIT,
        STEP_SEC_TEST,
        STEP_SEC_MUL,
        STEP_SEC_FIX,
        STEP_MIN_MUL,
        STEP_MIN_FIX,
        STEP_HR_MUL,
        STEP_HR_FIX,
        STEP_BACK64,
        STEP_BACK4,
        STEP_BACK_MON,
        STEP_FWD64,
        STEP_FWD4,
        STEP_FWD_MON,
        STEP_EMIT
    } t_step;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_ACCEPT,
        C_SEC_OK,
        C_DAY_LE_M64,
        C_DAY_LE_M4,
        C_DAY_LT_1,
        C_DAY_GT_64,
        C_DAY_GT_4,
        C_DAY_GT_LEN,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_SEC,
        OP_MUL_MIN,
        OP_MUL_HR,
        OP_FIX_SEC,
        OP_FIX_MIN,
        OP_FIX_HR,
        OP_BACK64,
        OP_BACK4,
        OP_BACK_MON,
        OP_FWD64,
        OP_FWD4,
        OP_FWD_MON,
        OP_EMIT
    } t_op;

    // One control word: when cond holds, run op and go to tgt_true, else go to tgt_false
    typedef struct packed {
        t_cond cond;
        t_op   op;
        t_step tgt_true;
        t_step tgt_false;
    } t_uword;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            STEP_WAIT:     w = '{C_IN_ACCEPT,  OP_LOAD,     STEP_SEC_TEST, STEP_WAIT};
            STEP_SEC_TEST: w = '{C_SEC_OK,     OP_NOP,      STEP_MIN_MUL,  STEP_SEC_MUL};
            STEP_SEC_MUL:  w = '{C_ALWAYS,     OP_MUL_SEC,  STEP_SEC_FIX,  STEP_SEC_FIX};
            STEP_SEC_FIX:  w = '{C_ALWAYS,     OP_FIX_SEC,  STEP_MIN_MUL,  STEP_MIN_MUL};
            STEP_MIN_MUL:  w = '{C_ALWAYS,     OP_MUL_MIN,  STEP_MIN_FIX,  STEP_MIN_FIX};
            STEP_MIN_FIX:  w = '{C_ALWAYS,     OP_FIX_MIN,  STEP_HR_MUL,   STEP_HR_MUL};
            STEP_HR_MUL:   w = '{C_ALWAYS,     OP_MUL_HR,   STEP_HR_FIX,   STEP_HR_FIX};
            STEP_HR_FIX:   w = '{C_ALWAYS,     OP_FIX_HR,   STEP_BACK64,   STEP_BACK64};
            STEP_BACK64:   w = '{C_DAY_LE_M64, OP_BACK64,   STEP_BACK64,   STEP_BACK4};
            STEP_BACK4:    w = '{C_DAY_LE_M4,  OP_BACK4,    STEP_BACK4,    STEP_BACK_MON};
            STEP_BACK_MON: w = '{C_DAY_LT_1,   OP_BACK_MON, STEP_BACK_MON, STEP_FWD64};
            STEP_FWD64:    w = '{C_DAY_GT_64,  OP_FWD64,    STEP_FWD64,    STEP_FWD4};
            STEP_FWD4:     w = '{C_DAY_GT_4,   OP_FWD4,     STEP_FWD4,     STEP_FWD_MON};
            STEP_FWD_MON:  w = '{C_DAY_GT_LEN, OP_FWD_MON,  STEP_FWD_MON,  STEP_EMIT};
            STEP_EMIT:     w = '{C_OUT_FREE,   OP_EMIT,     STEP_WAIT,     STEP_EMIT};
            default:       w = '{C_ALWAYS,     OP_NOP,      STEP_WAIT,     STEP_WAIT};
        endcase
        return w;
    endfunction

    // February gains a day when the low two bits of the year are zero
    function automatic logic [4:0] days_in(input logic [MON_W-1:0] mon,
                                           input logic [WIDE_W-1:0] year);
        logic [4:0] n;
        case (mon)
            4'd1:    n = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd3:    n = 5'd30;
            4'd5:    n = 5'd30;
            4'd8:    n = 5'd30;
            4'd10:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

[rtl/core/cfn_if.sv]
// Input and output word channels of the calendar field normalizer.
interface cfn_in_if import cfn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] second_in;
    logic signed [FIELD_W-1:0] minute_in;
    logic signed [FIELD_W-1:0] hour_in;
    logic signed [FIELD_W-1:0] day_in;
    logic        [MON_W-1:0]   month_in;
    logic signed [FIELD_W-1:0] year_in;

    modport source (output valid, second_in, minute_in, hour_in, day_in, month_in, year_in,
                    input ready);
    modport sink   (input valid, second_in, minute_in, hour_in, day_in, month_in, year_in,
                    output ready);
endinterface

interface cfn_out_if import cfn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic        [5:0]        second_out;
    logic        [5:0]        minute_out;
    logic        [4:0]        hour_out;
    logic        [4:0]        day_out;
    logic        [MON_W-1:0]  month_out;
    logic signed [WIDE_W-1:0] year_out;

    modport source (output valid, second_out, minute_out, hour_out, day_out, month_out, year_out,
                    input ready);
    modport sink   (input valid, second_out, minute_out, hour_out, day_out, month_out, year_out,
                    output ready);
endinterface

[rtl/core/calendar_field_normalizer.sv]
// Top level of the calendar field normalizer: microcoded sequencer and its datapath.
//
// Use: present a broken-down date and time on i_in_word (valid/ready); the normalized
// word comes out on o_out_word (valid/ready). Seconds, minutes and hours are reduced by
// floor division and carried upward, then the day carry walks the calendar: first in
// 64-year and 4-year blocks, then one month per cycle. i_cfg_we/i_cfg_wdata set the leap
// second allowance; write it only while the block is idle.
//
// Sequencing: one step of the microcode program runs per cycle; the month walk covers at
// most 48 months after the block steps. One word is in work at a time: the next word is
// taken the cycle after the emit step.
//
// The output word sits in its own register, so a new input word is taken as soon as the
// previous one has moved there, even while the receiver stalls. A finished word waits in
// the last program step until the output register is free.
//
// Reset: synchronous, active low. Returns the sequencer to its wait step, empties the
// output register and sets the leap second allowance to one.
module calendar_field_normalizer import cfn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ALLOW_W-1:0] i_cfg_wdata,
    cfn_in_if.sink             i_in_word,
    cfn_out_if.source          o_out_word
);

    // sequencer
    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   cond_ok;
    t_op    op_go;

    // datapath
    logic        [ALLOW_W-1:0] r_allow;
    logic signed [FIELD_W-1:0] r_sec;
    logic signed [WIDE_W-1:0]  r_min;
    logic signed [WIDE_W-1:0]  r_hour;
    logic signed [WIDE_W-1:0]  r_day;
    logic        [MON_W-1:0]   r_mon;
    logic signed [WIDE_W-1:0]  r_year;
    logic        [PROD_W-1:0]  r_prod;

    // output register
    logic                     r_out_valid;
    logic        [5:0]        r_out_sec;
    logic        [5:0]        r_out_min;
    logic        [4:0]        r_out_hour;
    logic        [4:0]        r_out_day;
    logic        [MON_W-1:0]  r_out_mon;
    logic signed [WIDE_W-1:0] r_out_year;

    logic                     in_accept;
    logic                     out_free;
    logic                     sec_ok;
    logic        [4:0]        len_cur;
    logic        [4:0]        len_prev;
    logic        [MON_W-1:0]  mon_prev;
    logic signed [WIDE_W-1:0] year_prev;
    logic signed [17:0]       mul_n;
    logic        [17:0]       mul_off;
    logic        [17:0]       mul_k;
    logic        [17:0]       mul_u;
    logic signed [17:0]       quot;
    logic signed [17:0]       quot60;
    logic signed [17:0]       quot24;
    logic signed [17:0]       sec_wide;

    assign in_accept = i_in_word.valid && i_in_word.ready;
    assign out_free  = !r_out_valid || o_out_word.ready;
    assign i_in_word.ready = (r_step == STEP_WAIT);

    assign sec_ok = !r_sec[FIELD_W-1] && (r_sec[14:0] <= (SEC_MAX + 15'(r_allow)));

    // month lengths for the forward and backward walk
    assign len_cur   = days_in(r_mon, r_year);
    assign mon_prev  = (r_mon == 4'd0) ? LAST_MONTH : (r_mon - 4'd1);
    assign year_prev = (r_mon == 4'd0) ? (r_year - 17'sd1) : r_year;
    assign len_prev  = days_in(mon_prev, year_prev);

    // multiplier operands: bias the dividend positive, then multiply by the reciprocal
    always_comb begin
        case (op_go)
            OP_MUL_SEC: begin
                mul_n   = 18'(r_sec);
                mul_off = OFF60;
                mul_k   = K60;
            end
            OP_MUL_MIN: begin
                mul_n   = 18'(r_min);
                mul_off = OFF60;
                mul_k   = K60;
            end
            default: begin
                mul_n   = 18'(r_hour);
                mul_off = OFF24;
                mul_k   = K24;
            end
        endcase
        mul_u = 18'(mul_n) + mul_off;
    end

    // floor quotient after removing the bias
    assign quot60   = $signed(18'(r_prod[34:23]) - BIAS60);
    assign quot24   = $signed(18'(r_prod[34:22]) - BIAS24);
    assign quot     = (op_go == OP_FIX_HR) ? quot24 : quot60;
    assign sec_wide = 18'(r_sec);

    // condition select
    always_comb begin
        case (uw.cond)
            C_ALWAYS:     cond_ok = 1'b1;
            C_IN_ACCEPT:  cond_ok = in_accept;
            C_SEC_OK:     cond_ok = sec_ok;
            C_DAY_LE_M64: cond_ok = (r_day <= -DAYS_64Y);
            C_DAY_LE_M4:  cond_ok = (r_day <= -DAYS_4Y);
            C_DAY_LT_1:   cond_ok = (r_day < 17'sd1);
            C_DAY_GT_64:  cond_ok = (r_day > DAYS_64Y);
            C_DAY_GT_4:   cond_ok = (r_day > DAYS_4Y);
            C_DAY_GT_LEN: cond_ok = (r_day > $signed(17'(len_cur)));
            C_OUT_FREE:   cond_ok = out_free;
            default:      cond_ok = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        uw     = ucode(r_step);
        n_step = cond_ok ? uw.tgt_true : uw.tgt_false;
    end

    // control output: the op runs only when its condition holds
    always_comb begin
        op_go = cond_ok ? uw.op : OP_NOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow <= ALLOW_RESET;
        end else if (i_cfg_we) begin
            r_allow <= i_cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (op_go)
            OP_LOAD: begin
                r_sec  <= i_in_word.second_in;
                r_min  <= 17'(i_in_word.minute_in);
                r_hour <= 17'(i_in_word.hour_in);
                r_day  <= 17'(i_in_word.day_in);
                // fold month codes twelve and up into the next year
                if (i_in_word.month_in > LAST_MONTH) begin
                    r_mon  <= i_in_word.month_in - MONTHS;
                    r_year <= 17'(i_in_word.year_in) + 17'sd1;
                end else begin
                    r_mon  <= i_in_word.month_in;
                    r_year <= 17'(i_in_word.year_in);
                end
            end
            OP_MUL_SEC, OP_MUL_MIN, OP_MUL_HR: begin
                r_prod <= 35'(mul_u[16:0]) * 35'(mul_k);
            end
            OP_FIX_SEC: begin
                r_min <= r_min + 17'(quot);
                r_sec <= 16'(sec_wide - ((quot <<< 6) - (quot <<< 2)));
            end
            OP_FIX_MIN: begin
                r_hour <= r_hour + 17'(quot);
                r_min  <= 17'(18'(r_min) - ((quot <<< 6) - (quot <<< 2)));
            end
            OP_FIX_HR: begin
                r_day  <= r_day + 17'(quot);
                r_hour <= 17'(18'(r_hour) - ((quot <<< 4) + (quot <<< 3)));
            end
            OP_BACK64: begin
                r_day  <= r_day + DAYS_64Y;
                r_year <= r_year - YEARS_64;
            end
            OP_BACK4: begin
                r_day  <= r_day + DAYS_4Y;
                r_year <= r_year - YEARS_4;
            end
            OP_BACK_MON: begin
                r_mon  <= mon_prev;
                r_year <= year_prev;
                r_day  <= r_day + $signed(17'(len_prev));
            end
            OP_FWD64: begin
                r_day  <= r_day - DAYS_64Y;
                r_year <= r_year + YEARS_64;
            end
            OP_FWD4: begin
                r_day  <= r_day - DAYS_4Y;
                r_year <= r_year + YEARS_4;
            end
            OP_FWD_MON: begin
                r_day <= r_day - $signed(17'(len_cur));
                if (r_mon == LAST_MONTH) begin
                    r_mon  <= 4'd0;
                    r_year <= r_year + 17'sd1;
                end else begin
                    r_mon <= r_mon + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register: fill on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (op_go == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (o_out_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op_go == OP_EMIT) begin
            r_out_sec  <= r_sec[5:0];
            r_out_min  <= r_min[5:0];
            r_out_hour <= r_hour[4:0];
            r_out_day  <= r_day[4:0];
            r_out_mon  <= r_mon;
            r_out_year <= r_year;
        end
    end

    assign o_out_word.valid      = r_out_valid;
    assign o_out_word.second_out = r_out_sec;
    assign o_out_word.minute_out = r_out_min;
    assign o_out_word.hour_out   = r_out_hour;
    assign o_out_word.day_out    = r_out_day;
    assign o_out_word.month_out  = r_out_mon;
    assign o_out_word.year_out   = r_out_year;

    // an accepted word always starts the program at the seconds test
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_step == STEP_SEC_TEST))
        else $error("sequencer did not start after an accepted word");

    // a held output word always has its minute, hour and month in range and a nonzero day
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_min < 6'd60) && (r_out_hour < 5'd24) &&
                        (r_out_day != 5'd0) && (r_out_mon <= LAST_MONTH))
        else $error("output word out of range");

    // leaving the month walk, the day lies within its month
    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == STEP_FWD_MON) && !cond_ok) |->
            (r_day >= 17'sd1) && (r_day <= $signed(17'(len_cur))))
        else $error("day outside its month at the end of the walk");

endmodule
